>>> design/lwbc_pkg.sv
`timescale 1ns / 1ps

package lwbc_pkg;

    localparam int POOL_SLOTS_DEF = 16;

    localparam logic [1:0] OP_READ  = 2'd0;
    localparam logic [1:0] OP_WRITE = 2'd1;
    localparam logic [1:0] OP_FLUSH = 2'd2;
    localparam logic [1:0] OP_CLEAR = 2'd3;

    localparam logic [1:0] KIND_HIT       = 2'd0;
    localparam logic [1:0] KIND_FILL      = 2'd1;
    localparam logic [1:0] KIND_WRITEBACK = 2'd2;

    localparam logic [1:0] SCOPE_ALL  = 2'd0;
    localparam logic [1:0] SCOPE_FILE = 2'd1;
    localparam logic [1:0] SCOPE_POS  = 2'd2;

    // Contents of one cache slot as it travels around the ring.
    typedef struct packed {
        logic        valid;
        logic        dirty;
        logic [7:0]  file;
        logic [31:0] pos;
        logic [15:0] len;
        logic [31:0] stamp;
    } t_slot;

    typedef struct packed {
        logic [1:0]  kind;
        logic [3:0]  slot;
        logic [7:0]  file;
        logic [31:0] pos;
        logic [15:0] len;
    } t_res;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_APPLY,
        ST_FLUSH,
        ST_DONE
    } t_state;

endpackage

>>> design/lru_writeback_block_cache_unit.sv
`timescale 1ns / 1ps

// Channel | Direction | Handshake                  | Payload
// input   | in        | i_in_valid / o_in_stall    | op, file_id, position, block_length, scope
// output  | out       | o_out_valid / i_out_stall  | result_kind, slot, res_*, last
//
// The slots live in a ring of cells that rotates one place per cycle while an item is worked on,
// so the head cell sees the slots in index order and a full rotation restores the original order.
// A read or write takes two rotations (search, then update) and a done step, with the ring held
// in place once for a dirty victim; a flush or clear takes one rotation and a done step.
// The ring freezes while the output register holds an item that is stalled.
// Reset is synchronous and active low; it empties every slot and zeroes the use clock.
// One item is worked on at a time; o_in_stall is high until its results are all queued.
module lru_writeback_block_cache_unit #(
    parameter int POOL_SLOTS = lwbc_pkg::POOL_SLOTS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_op,
    input  logic [7:0]  i_file_id,
    input  logic [31:0] i_position,
    input  logic [15:0] i_block_length,
    input  logic [1:0]  i_scope,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [1:0]  o_result_kind,
    output logic [3:0]  o_slot,
    output logic [7:0]  o_res_file,
    output logic [31:0] o_res_position,
    output logic [15:0] o_res_length,
    output logic        o_last
);

    localparam int IW = $clog2(POOL_SLOTS);
    localparam logic [IW-1:0] LAST_IDX = IW'(POOL_SLOTS - 1);

    lwbc_pkg::t_slot w_slot [POOL_SLOTS];
    lwbc_pkg::t_slot w_fb;
    lwbc_pkg::t_slot w_head;
    logic            w_shift;
    logic            w_end;
    logic            w_adv;
    logic            w_accept;

    // The tail cell receives the (possibly updated) head; every other cell its neighbor.
    for (genvar k = 0; k < POOL_SLOTS; k++) begin : g_ring
        lwbc_pkg::t_slot w_in;
        if (k == POOL_SLOTS - 1) begin : g_tail
            assign w_in = w_fb;
        end else begin : g_body
            assign w_in = w_slot[k+1];
        end
        lwbc_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_shift (w_shift),
            .i_slot  (w_in),
            .o_slot  (w_slot[k])
        );
    end

    assign w_head = w_slot[0];

    lwbc_pkg::t_state r_state, n_state;
    logic [IW-1:0]    r_cnt, n_cnt;
    logic [1:0]       r_op, n_op;
    logic [7:0]       r_file, n_file;
    logic [31:0]      r_pos, n_pos;
    logic [15:0]      r_len, n_len;
    logic [1:0]       r_scope, n_scope;
    logic [31:0]      r_clk_use, n_clk_use;
    logic             r_hit_f, n_hit_f;
    logic [IW-1:0]    r_hit_idx, n_hit_idx;
    logic             r_free_f, n_free_f;
    logic [IW-1:0]    r_free_idx, n_free_idx;
    logic [31:0]      r_min, n_min;
    logic [IW-1:0]    r_min_idx, n_min_idx;
    logic             r_wb_done, n_wb_done;
    logic             r_pend_v, n_pend_v;
    lwbc_pkg::t_res   r_pend, n_pend;
    logic             r_out_v, n_out_v;
    lwbc_pkg::t_res   r_out, n_out;
    logic             r_out_last, n_out_last;

    logic             w_emit;
    lwbc_pkg::t_res   w_res;
    logic [IW-1:0]    w_target;
    logic [IW+3:0]    w_slot_wide;
    logic             w_match;
    logic             w_insc;

    assign w_adv      = !r_out_v || !i_out_stall;
    assign o_in_stall = (r_state != lwbc_pkg::ST_IDLE);
    assign w_accept   = i_in_valid && !o_in_stall;
    assign w_end      = w_shift && (r_cnt == LAST_IDX);
    assign w_target   = r_hit_f ? r_hit_idx : (r_free_f ? r_free_idx : r_min_idx);
    assign w_slot_wide = {4'b0, r_cnt};
    assign w_match    = w_head.valid && (w_head.file == r_file) && (w_head.pos == r_pos);

    always_comb begin
        case (r_scope)
            lwbc_pkg::SCOPE_ALL:  w_insc = w_head.valid;
            lwbc_pkg::SCOPE_FILE: w_insc = w_head.valid && (w_head.file == r_file);
            lwbc_pkg::SCOPE_POS:  w_insc = w_match;
            default:              w_insc = 1'b0;
        endcase
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            lwbc_pkg::ST_IDLE: begin
                if (w_accept) begin
                    n_state = (i_op == lwbc_pkg::OP_READ || i_op == lwbc_pkg::OP_WRITE)
                              ? lwbc_pkg::ST_SCAN : lwbc_pkg::ST_FLUSH;
                end
            end
            lwbc_pkg::ST_SCAN: begin
                if (w_end) n_state = lwbc_pkg::ST_APPLY;
            end
            lwbc_pkg::ST_APPLY, lwbc_pkg::ST_FLUSH: begin
                if (w_end) n_state = lwbc_pkg::ST_DONE;
            end
            lwbc_pkg::ST_DONE: begin
                if (!r_pend_v || w_adv) n_state = lwbc_pkg::ST_IDLE;
            end
            default: n_state = lwbc_pkg::ST_IDLE;
        endcase
    end

    // Ring control, scan bookkeeping and result queueing.
    always_comb begin
        n_cnt      = r_cnt;
        n_op       = r_op;
        n_file     = r_file;
        n_pos      = r_pos;
        n_len      = r_len;
        n_scope    = r_scope;
        n_clk_use  = r_clk_use;
        n_hit_f    = r_hit_f;
        n_hit_idx  = r_hit_idx;
        n_free_f   = r_free_f;
        n_free_idx = r_free_idx;
        n_min      = r_min;
        n_min_idx  = r_min_idx;
        n_wb_done  = r_wb_done;
        n_pend_v   = r_pend_v;
        n_pend     = r_pend;
        n_out_v    = r_out_v;
        n_out      = r_out;
        n_out_last = r_out_last;
        w_fb       = w_head;
        w_shift    = 1'b0;
        w_emit     = 1'b0;
        w_res.kind = lwbc_pkg::KIND_HIT;
        w_res.slot = w_slot_wide[3:0];
        w_res.file = w_head.file;
        w_res.pos  = w_head.pos;
        w_res.len  = w_head.len;

        case (r_state)
            lwbc_pkg::ST_IDLE: begin
                if (w_accept) begin
                    n_op      = i_op;
                    n_file    = i_file_id;
                    n_pos     = i_position;
                    n_len     = i_block_length;
                    n_scope   = i_scope;
                    n_hit_f   = 1'b0;
                    n_free_f  = 1'b0;
                    n_wb_done = 1'b0;
                end
            end
            lwbc_pkg::ST_SCAN: begin
                if (w_adv) begin
                    w_shift = 1'b1;
                    if (w_match && !r_hit_f) begin
                        n_hit_f   = 1'b1;
                        n_hit_idx = r_cnt;
                    end
                    if (!w_head.valid && !r_free_f) begin
                        n_free_f   = 1'b1;
                        n_free_idx = r_cnt;
                    end
                    // Strict compare keeps the lowest index among equal stamps.
                    if (r_cnt == '0 || w_head.stamp < r_min) begin
                        n_min     = w_head.stamp;
                        n_min_idx = r_cnt;
                    end
                end
            end
            lwbc_pkg::ST_APPLY: begin
                if (w_adv) begin
                    w_shift = 1'b1;
                    if (r_cnt == w_target) begin
                        if (r_hit_f) begin
                            if (w_head.stamp != r_clk_use) begin
                                n_clk_use   = r_clk_use + 32'd1;
                                w_fb.stamp  = r_clk_use + 32'd1;
                            end
                            if (r_op == lwbc_pkg::OP_WRITE) w_fb.dirty = 1'b1;
                            w_emit = 1'b1;
                        end else if (!r_free_f && w_head.dirty && !r_wb_done) begin
                            // Dirty victim: report its writeback and hold the ring in place.
                            w_shift    = 1'b0;
                            n_wb_done  = 1'b1;
                            w_emit     = 1'b1;
                            w_res.kind = lwbc_pkg::KIND_WRITEBACK;
                        end else begin
                            n_clk_use  = r_clk_use + 32'd1;
                            w_fb.valid = 1'b1;
                            w_fb.dirty = (r_op == lwbc_pkg::OP_WRITE);
                            w_fb.file  = r_file;
                            w_fb.pos   = r_pos;
                            w_fb.len   = r_len;
                            w_fb.stamp = r_clk_use + 32'd1;
                            w_emit     = 1'b1;
                            w_res.kind = lwbc_pkg::KIND_FILL;
                            w_res.file = r_file;
                            w_res.pos  = r_pos;
                            w_res.len  = r_len;
                        end
                    end
                end
            end
            lwbc_pkg::ST_FLUSH: begin
                if (w_adv) begin
                    w_shift = 1'b1;
                    if (w_insc && w_head.dirty) begin
                        w_emit     = 1'b1;
                        w_res.kind = lwbc_pkg::KIND_WRITEBACK;
                        w_fb.dirty = 1'b0;
                    end
                    if (w_insc && r_op == lwbc_pkg::OP_CLEAR) w_fb.valid = 1'b0;
                end
            end
            default: begin
            end
        endcase

        if (w_shift) n_cnt = (r_cnt == LAST_IDX) ? '0 : r_cnt + 1'b1;

        // One result is held back so that the final one can carry the last flag.
        if (!i_out_stall) n_out_v = 1'b0;
        if (w_emit) begin
            if (r_pend_v) begin
                n_out      = r_pend;
                n_out_last = 1'b0;
                n_out_v    = 1'b1;
            end
            n_pend   = w_res;
            n_pend_v = 1'b1;
        end
        if (r_state == lwbc_pkg::ST_DONE && r_pend_v && w_adv) begin
            n_out      = r_pend;
            n_out_last = 1'b1;
            n_out_v    = 1'b1;
            n_pend_v   = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= lwbc_pkg::ST_IDLE;
            r_cnt     <= '0;
            r_clk_use <= '0;
            r_hit_f   <= 1'b0;
            r_free_f  <= 1'b0;
            r_wb_done <= 1'b0;
            r_pend_v  <= 1'b0;
            r_out_v   <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_cnt     <= n_cnt;
            r_clk_use <= n_clk_use;
            r_hit_f   <= n_hit_f;
            r_free_f  <= n_free_f;
            r_wb_done <= n_wb_done;
            r_pend_v  <= n_pend_v;
            r_out_v   <= n_out_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op       <= n_op;
        r_file     <= n_file;
        r_pos      <= n_pos;
        r_len      <= n_len;
        r_scope    <= n_scope;
        r_hit_idx  <= n_hit_idx;
        r_free_idx <= n_free_idx;
        r_min      <= n_min;
        r_min_idx  <= n_min_idx;
        r_pend     <= n_pend;
        r_out      <= n_out;
        r_out_last <= n_out_last;
    end

    assign o_out_valid    = r_out_v;
    assign o_result_kind  = r_out.kind;
    assign o_slot         = r_out.slot;
    assign o_res_file     = r_out.file;
    assign o_res_position = r_out.pos;
    assign o_res_length   = r_out.len;
    assign o_last         = r_out_last;

`ifndef SYNTHESIS
    a_pend_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_state == lwbc_pkg::ST_IDLE && r_pend_v))
        else $error("held result left behind in idle");

    a_wb_apply: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_wb_done |-> (r_state != lwbc_pkg::ST_SCAN && r_state != lwbc_pkg::ST_FLUSH))
        else $error("victim writeback flag still set during a scan");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> r_state != lwbc_pkg::ST_IDLE)
        else $error("accepted item did not start work");
`endif

endmodule

>>> design/lwbc_cell.sv
`timescale 1ns / 1ps

// One slot of the ring. It takes its neighbor's contents whenever the ring shifts.
module lwbc_cell (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_shift,
    input  lwbc_pkg::t_slot i_slot,
    output lwbc_pkg::t_slot o_slot
);

    lwbc_pkg::t_slot r_slot;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot.valid <= 1'b0;
            r_slot.dirty <= 1'b0;
            r_slot.stamp <= '0;
        end else if (i_shift) begin
            r_slot <= i_slot;
        end
    end

    assign o_slot = r_slot;

endmodule
